@@ rtl/dpa_pkg.sv @@
// Shared types and constants for the data-ROM port address unit.
`default_nettype none
package dpa_pkg;

    localparam int unsigned OFS_W   = 24;
    localparam int unsigned ADJ_W   = 16;
    localparam int unsigned MODE_W  = 8;
    localparam int unsigned WCODE_W = 2;
    localparam int unsigned RLOG_W  = 5;
    localparam int unsigned CIDX_W  = 2;
    localparam int unsigned CDAT_W  = 16;

    // Largest meaningful ROM size exponent and its reset value
    localparam logic [RLOG_W-1:0] ROM_LOG2_MAX = 5'd24;
    localparam logic [RLOG_W-1:0] ROM_LOG2_RST = 5'd23;
    // Window code that covers the whole 8 MB, so never forces zero
    localparam logic [WCODE_W-1:0] WCODE_FULL  = 2'd3;
    // Sum bit that marks an address outside the 4 MB window
    localparam int unsigned OUTSIDE_BIT = 22;
    // Log2 of the smallest (1 MB) window
    localparam int unsigned WIN_LOG2_MIN = 20;

    // Item kinds
    typedef enum logic [2:0] {
        KIND_WR_OFS   = 3'd0,
        KIND_WR_ADJ   = 3'd1,
        KIND_READ_ADV = 3'd2,
        KIND_TRIG_A   = 3'd3,
        KIND_TRIG_B   = 3'd4,
        KIND_TRIG_C   = 3'd5,
        KIND_READ     = 3'd6
    } kind_t;

    // Configuration register indexes
    typedef enum logic [CIDX_W-1:0] {
        REG_MODE   = 2'd0,
        REG_WCODE  = 2'd1,
        REG_STRIDE = 2'd2,
        REG_RLOG   = 2'd3
    } reg_idx_t;

    // Mode bit positions
    localparam int unsigned MB_STRIDE_EN  = 0;
    localparam int unsigned MB_ADJ_EN     = 1;
    localparam int unsigned MB_STRIDE_SGN = 2;
    localparam int unsigned MB_ADJ_SGN    = 3;
    localparam int unsigned MB_STEP_ADJ   = 4;

    // Settings the address calculation needs
    typedef struct packed {
        logic                adj_en;
        logic                adj_signed;
        logic [WCODE_W-1:0]  win_code;
        logic [RLOG_W-1:0]   rom_log2;
    } calc_cfg_t;

    // 16-bit value widened to the offset width, optionally sign-extended
    function automatic logic [OFS_W-1:0] widen16(input logic [ADJ_W-1:0] v,
                                                 input logic sgn);
        logic [OFS_W-ADJ_W-1:0] ext;
        begin
            ext = (sgn && v[ADJ_W-1]) ? '1 : '0;
            widen16 = {ext, v};
        end
    endfunction

endpackage
`default_nettype wire

@@ rtl/dpa_addr_calc.sv @@
// ROM fetch address calculation: offset plus adjust, window test and mirroring mask.
`default_nettype none
module dpa_addr_calc
    import dpa_pkg::*;
(
    input  wire calc_cfg_t        cfg,
    input  wire logic [OFS_W-1:0] offset,
    input  wire logic [ADJ_W-1:0] adjust,
    output logic      [OFS_W-1:0] rom_addr,
    output logic                  force_zero
);

    logic [ADJ_W-1:0]  adj_sel;
    logic [OFS_W-1:0]  sum;
    logic [OFS_W-1:0]  win_mask;
    logic [OFS_W-1:0]  rom_mask;
    logic [RLOG_W-1:0] rlog;

    // Sum of offset and adjust; only the low 24 bits matter downstream
    assign adj_sel = cfg.adj_en ? adjust : '0;
    assign sum     = offset + widen16(adj_sel, cfg.adj_signed);

    // Window mask: 1, 2, 4 or 8 MB
    always_comb begin
        case (cfg.win_code)
            2'd0:    win_mask = {{(OFS_W-WIN_LOG2_MIN){1'b0}}, {WIN_LOG2_MIN{1'b1}}};
            2'd1:    win_mask = {{(OFS_W-WIN_LOG2_MIN-1){1'b0}}, {(WIN_LOG2_MIN+1){1'b1}}};
            2'd2:    win_mask = {{(OFS_W-WIN_LOG2_MIN-2){1'b0}}, {(WIN_LOG2_MIN+2){1'b1}}};
            default: win_mask = {{(OFS_W-WIN_LOG2_MIN-3){1'b0}}, {(WIN_LOG2_MIN+3){1'b1}}};
        endcase
    end

    // Mirroring mask, size exponent clamped at 24
    assign rlog     = (cfg.rom_log2 > ROM_LOG2_MAX) ? ROM_LOG2_MAX : cfg.rom_log2;
    assign rom_mask = ~({OFS_W{1'b1}} << rlog);

    assign force_zero = (cfg.win_code != WCODE_FULL) && sum[OUTSIDE_BIT];
    assign rom_addr   = force_zero ? '0 : (sum & win_mask & rom_mask);

endmodule
`default_nettype wire

@@ rtl/data_rom_port_address_unit.sv @@
// Top level of the data-ROM port address unit.
// A result is registered and appears in the cycle after its transaction is
// accepted. One transaction per cycle unless a held result stalls s_ready;
// offset, adjust and sum logic sits between state and result registers.
// Reset (aresetn, synchronous, active low) clears offset, adjust and all
// configuration registers except the ROM size exponent, which resets to 23.
`default_nettype none
module data_rom_port_address_unit
    import dpa_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // configuration write channel
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [CIDX_W-1:0]  cfg_index,
    input  wire logic [CDAT_W-1:0]  cfg_data,
    // input transactions
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [2:0]         s_kind,
    input  wire logic [OFS_W-1:0]   s_write_value,
    // results
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic      [OFS_W-1:0]   m_rom_addr,
    output logic                    m_force_zero,
    output logic      [OFS_W-1:0]   m_offset_now,
    output logic      [ADJ_W-1:0]   m_adjust_now
);

    logic [MODE_W-1:0]  mode_reg;
    logic [WCODE_W-1:0] wcode_reg;
    logic [ADJ_W-1:0]   stride_reg;
    logic [RLOG_W-1:0]  rlog_reg;
    logic [OFS_W-1:0]   offset_reg, offset_next;
    logic [ADJ_W-1:0]   adjust_reg, adjust_next;
    logic               m_valid_reg, m_valid_next;
    logic [OFS_W-1:0]   rom_addr_reg;
    logic               force_zero_reg;
    logic [OFS_W-1:0]   offset_now_reg;
    logic [ADJ_W-1:0]   adjust_now_reg;

    logic               s_accept;
    logic               has_result;
    logic [ADJ_W-1:0]   step;
    logic [2:0]         trig_sel;
    kind_t              kind;
    calc_cfg_t          calc_cfg;
    logic [OFS_W-1:0]   calc_addr;
    logic               calc_zero;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_accept  = s_valid && s_ready;
    assign kind      = kind_t'(s_kind);
    assign trig_sel  = mode_reg[MODE_W-1:MODE_W-3];
    assign step      = mode_reg[MB_STRIDE_EN] ? stride_reg : ADJ_W'(1);

    // Next offset and adjust for this transaction
    always_comb begin
        offset_next = offset_reg;
        adjust_next = adjust_reg;
        has_result  = 1'b0;
        case (kind)
            KIND_WR_OFS: begin
                offset_next = s_write_value;
            end
            KIND_WR_ADJ: begin
                adjust_next = s_write_value[ADJ_W-1:0];
            end
            KIND_READ_ADV: begin
                has_result = 1'b1;
                if (mode_reg[MB_STEP_ADJ]) begin
                    adjust_next = adjust_reg + step;
                end else begin
                    offset_next = offset_reg + widen16(step, mode_reg[MB_STRIDE_SGN]);
                end
            end
            KIND_TRIG_A, KIND_TRIG_B, KIND_TRIG_C: begin
                if (trig_sel == (s_kind - 3'd2)) begin
                    has_result  = 1'b1;
                    offset_next = offset_reg + widen16(adjust_reg, mode_reg[MB_ADJ_SGN]);
                end
            end
            KIND_READ: begin
                has_result = 1'b1;
            end
            default: begin
                has_result = 1'b0;
            end
        endcase
    end

    assign calc_cfg.adj_en     = mode_reg[MB_ADJ_EN];
    assign calc_cfg.adj_signed = mode_reg[MB_ADJ_SGN];
    assign calc_cfg.win_code   = wcode_reg;
    assign calc_cfg.rom_log2   = rlog_reg;

    dpa_addr_calc u_calc (
        .cfg        (calc_cfg),
        .offset     (offset_next),
        .adjust     (adjust_next),
        .rom_addr   (calc_addr),
        .force_zero (calc_zero)
    );

    // Result valid: set by a transaction that reads, cleared when taken
    always_comb begin
        if (s_accept && has_result) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= '0;
            wcode_reg   <= '0;
            stride_reg  <= '0;
            rlog_reg    <= ROM_LOG2_RST;
            offset_reg  <= '0;
            adjust_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (s_accept) begin
                offset_reg <= offset_next;
                adjust_reg <= adjust_next;
            end
            if (cfg_valid && cfg_ready) begin
                case (reg_idx_t'(cfg_index))
                    REG_MODE:   mode_reg   <= cfg_data[MODE_W-1:0];
                    REG_WCODE:  wcode_reg  <= cfg_data[WCODE_W-1:0];
                    REG_STRIDE: stride_reg <= cfg_data[ADJ_W-1:0];
                    REG_RLOG:   rlog_reg   <= cfg_data[RLOG_W-1:0];
                    default:    mode_reg   <= mode_reg;
                endcase
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (s_accept && has_result) begin
            rom_addr_reg   <= calc_addr;
            force_zero_reg <= calc_zero;
            offset_now_reg <= offset_next;
            adjust_now_reg <= adjust_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_rom_addr   = rom_addr_reg;
    assign m_force_zero = force_zero_reg;
    assign m_offset_now = offset_now_reg;
    assign m_adjust_now = adjust_now_reg;

endmodule
`default_nettype wire
